[sv/tri_pkg.sv]
package tri_pkg;

  localparam int CW         = 29;
  localparam int RW         = 28;
  localparam int TOL_W      = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DFW        = CW + 1;
  localparam int SQW        = 2 * CW;
  localparam int TW         = SQW + 1;
  localparam int CBW        = TW + 1;
  localparam int DPW        = 2 * DFW;
  localparam int DAW        = DPW + 1;
  localparam int DEN_W      = DAW + 1;
  localparam int PRW        = CBW + DFW;
  localparam int NUM_W      = PRW + 1;
  localparam int QUO_W      = CW + 1;
  localparam int MUL_CHUNK  = 30;
  localparam int MUL_LAT    = 4;
  localparam int DIV_LAT    = QUO_W + 3;
  localparam int PIPE_LAT   = 2 * MUL_LAT + DIV_LAT + 5;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ALLX = 2'd1;
  localparam logic [1:0] ST_COLL = 2'd2;

  typedef struct packed {
    logic signed [CW-1:0]  xa;
    logic signed [CW-1:0]  ya;
    logic [RW-1:0]         ra;
    logic signed [CW-1:0]  xb;
    logic signed [CW-1:0]  yb;
    logic [RW-1:0]         rb;
    logic signed [CW-1:0]  xc;
    logic signed [CW-1:0]  yc;
    logic [RW-1:0]         rc;
    logic signed [DFW-1:0] dxb;
    logic signed [DFW-1:0] dyb;
    logic signed [DFW-1:0] dxc;
    logic signed [DFW-1:0] dyc;
    logic                  all_eq;
  } tri_item_t;

endpackage

[sv/tri_ifs.sv]
interface tri_in_if import tri_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] anchor_a_x;
  logic signed [CW-1:0] anchor_a_y;
  logic [RW-1:0]        range_a;
  logic signed [CW-1:0] anchor_b_x;
  logic signed [CW-1:0] anchor_b_y;
  logic [RW-1:0]        range_b;
  logic signed [CW-1:0] anchor_c_x;
  logic signed [CW-1:0] anchor_c_y;
  logic [RW-1:0]        range_c;

  modport source (output valid, anchor_a_x, anchor_a_y, range_a, anchor_b_x, anchor_b_y,
                  range_b, anchor_c_x, anchor_c_y, range_c, input ready);
  modport sink (input valid, anchor_a_x, anchor_a_y, range_a, anchor_b_x, anchor_b_y,
                range_b, anchor_c_x, anchor_c_y, range_c, output ready);
endinterface

interface tri_out_if import tri_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] target_x;
  logic signed [CW-1:0] target_y;
  logic [1:0]           fix_status;

  modport source (output valid, target_x, target_y, fix_status, input ready);
  modport sink (input valid, target_x, target_y, fix_status, output ready);
endinterface

interface tri_cfg_if import tri_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[sv/tri_mul.sv]
module tri_mul import tri_pkg::*; #(
  parameter int AW = 30,
  parameter int BW = 30
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NCH = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AEW = NCH * MUL_CHUNK;
  localparam int PPW = MUL_CHUNK + BW;
  localparam int PW  = AW + BW;

  logic [AW-1:0]         amag;
  logic [BW-1:0]         bmag;
  logic [AEW-1:0]        am_r;
  logic [BW-1:0]         bm_r;
  logic                  neg1_r;
  logic                  neg2_r;
  logic                  neg3_r;
  logic [PPW-1:0]        pp_r [NCH];
  logic [PW-1:0]         sum_nxt;
  logic [PW-1:0]         sum_r;
  logic signed [PW-1:0]  p_r;

  assign amag = a[AW-1] ? AW'(-a) : AW'(a);
  assign bmag = b[BW-1] ? BW'(-b) : BW'(b);

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NCH; k++) begin
      sum_nxt = sum_nxt + (PW'(pp_r[k]) << (k * MUL_CHUNK));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      am_r   <= AEW'(amag);
      bm_r   <= bmag;
      neg1_r <= a[AW-1] ^ b[BW-1];
      for (int k = 0; k < NCH; k++) begin
        pp_r[k] <= PPW'(am_r[k*MUL_CHUNK +: MUL_CHUNK]) * PPW'(bm_r);
      end
      neg2_r <= neg1_r;
      sum_r  <= sum_nxt;
      neg3_r <= neg2_r;
      p_r    <= neg3_r ? PW'(-signed'(sum_r)) : signed'(sum_r);
    end
  end

  assign p = p_r;

endmodule

[sv/tri_dly.sv]
module tri_dly #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign q = sh_r[N-1];

endmodule

[sv/tri_div.sv]
module tri_div import tri_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [NUM_W-1:0]     num,
  input  logic [DEN_W-1:0]     den,
  input  logic                 neg,
  output logic signed [CW-1:0] q
);

  logic [DEN_W-1:0] rem_r [QUO_W+1];
  logic [QUO_W-1:0] lo_r  [QUO_W+1];
  logic [QUO_W-1:0] qq_r  [QUO_W+1];
  logic [DEN_W-1:0] den_r [QUO_W+1];
  logic             neg_r [QUO_W+1];
  logic             ovf_r [QUO_W+1];

  logic [NUM_W-1:0] hi_ext;
  logic             ovf;
  logic             rup;
  logic [QUO_W:0]   qr;
  logic [QUO_W:0]   lim;
  logic [CW-1:0]    mag_r;
  logic             sn_r;
  logic [CW-1:0]    q_r;

  assign hi_ext = num >> QUO_W;
  assign ovf    = hi_ext >= NUM_W'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= ovf ? '0 : DEN_W'(hi_ext);
      lo_r[0]  <= num[QUO_W-1:0];
      qq_r[0]  <= '0;
      den_r[0] <= den;
      neg_r[0] <= neg;
      ovf_r[0] <= ovf;
    end
  end

  for (genvar k = 1; k <= QUO_W; k++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;

    assign t  = {rem_r[k-1], lo_r[k-1][QUO_W-1]};
    assign ge = t >= {1'b0, den_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DEN_W'(t - {1'b0, den_r[k-1]}) : DEN_W'(t);
        lo_r[k]  <= lo_r[k-1] << 1;
        qq_r[k]  <= {qq_r[k-1][QUO_W-2:0], ge};
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign rup = {rem_r[QUO_W], 1'b0} >= {1'b0, den_r[QUO_W]};
  assign qr  = (QUO_W+1)'(qq_r[QUO_W]) + (QUO_W+1)'(rup);
  assign lim = neg_r[QUO_W] ? ((QUO_W+1)'(1) << (CW-1))
                            : ((QUO_W+1)'(1) << (CW-1)) - (QUO_W+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= (ovf_r[QUO_W] || qr > lim) ? CW'(lim) : CW'(qr);
      sn_r  <= neg_r[QUO_W];
      q_r   <= sn_r ? ~mag_r + CW'(1) : mag_r;
    end
  end

  assign q = signed'(q_r);

endmodule

[sv/tri_fifo.sv]
module tri_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] ent_r [2];
  logic         wp_r;
  logic         rp_r;
  logic [1:0]   cnt_r;
  logic         push;
  logic         pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[sv/tri_front.sv]
module tri_front import tri_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tri_in_if.sink    in_ch,
  tri_cfg_if.sink   cfg_ch,
  output logic      item_valid,
  input  logic      item_ready,
  output tri_item_t item
);

  logic [TOL_W-1:0]      tol_r;
  logic signed [DFW-1:0] dxb;
  logic signed [DFW-1:0] dxc;
  logic [DFW-1:0]        adxb;
  logic [DFW-1:0]        adxc;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.data;
    end
  end

  assign dxb  = DFW'(in_ch.anchor_b_x) - DFW'(in_ch.anchor_a_x);
  assign dxc  = DFW'(in_ch.anchor_c_x) - DFW'(in_ch.anchor_a_x);
  assign adxb = dxb[DFW-1] ? DFW'(-dxb) : DFW'(dxb);
  assign adxc = dxc[DFW-1] ? DFW'(-dxc) : DFW'(dxc);

  always_comb begin
    item.xa     = in_ch.anchor_a_x;
    item.ya     = in_ch.anchor_a_y;
    item.ra     = in_ch.range_a;
    item.xb     = in_ch.anchor_b_x;
    item.yb     = in_ch.anchor_b_y;
    item.rb     = in_ch.range_b;
    item.xc     = in_ch.anchor_c_x;
    item.yc     = in_ch.anchor_c_y;
    item.rc     = in_ch.range_c;
    item.dxb    = dxb;
    item.dyb    = DFW'(in_ch.anchor_b_y) - DFW'(in_ch.anchor_a_y);
    item.dxc    = dxc;
    item.dyc    = DFW'(in_ch.anchor_c_y) - DFW'(in_ch.anchor_a_y);
    item.all_eq = (adxb < DFW'(tol_r)) && (adxc < DFW'(tol_r));
  end

  assign item_valid  = in_ch.valid;
  assign in_ch.ready = item_ready;

endmodule

[sv/tri_back.sv]
module tri_back import tri_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_valid,
  output logic       item_ready,
  input  tri_item_t  item,
  tri_out_if.source  out_ch
);

  localparam int D1W = 4 * DFW + 1;
  localparam int D2W = DEN_W + 3;

  logic                  en;
  logic [PIPE_LAT-1:0]   vld_r;
  tri_item_t             it_r;

  logic signed [CW-1:0]  ras;
  logic signed [CW-1:0]  rbs;
  logic signed [CW-1:0]  rcs;
  logic signed [SQW-1:0] sxa, sya, sra, sxb, syb, srb, sxc, syc, src;
  logic signed [DPW-1:0] pd1, pd2;
  logic [D1W-1:0]        dl1;

  logic signed [TW-1:0]  ta_r, tb_r, tc_r;
  logic signed [DAW-1:0] dd_r;
  logic signed [DFW-1:0] dxb_b_r, dyb_b_r, dxc_b_r, dyc_b_r;
  logic                  alleq_b_r;

  logic [DAW-1:0]        dabs;
  logic signed [CBW-1:0] cb_r, cc_r;
  logic signed [DFW-1:0] dxb_c_r, dyb_c_r, dxc_c_r, dyc_c_r;
  logic [DEN_W-1:0]      den_c_r;
  logic                  dneg_c_r;
  logic [1:0]            st_c_r;

  logic signed [PRW-1:0] p1, p2, p3, p4;
  logic [D2W-1:0]        dl2;

  logic signed [NUM_W-1:0] nx_r, ny_r;
  logic [DEN_W-1:0]        den_d_r;
  logic                    dneg_d_r;
  logic [1:0]              st_d_r;

  logic [NUM_W-1:0]      nmx_r, nmy_r;
  logic                  sx_r, sy_r;
  logic [DEN_W-1:0]      den_e_r;
  logic [1:0]            st_e_r;

  logic signed [CW-1:0]  qx, qy;
  logic [1:0]            st_q;

  logic                  out_valid_r;
  logic signed [CW-1:0]  tx_r, ty_r;
  logic [1:0]            st_r;

  assign en         = !out_valid_r || out_ch.ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_LAT-2:0], item_valid};
      out_valid_r <= vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it_r <= item;
    end
  end

  assign ras = signed'({1'b0, it_r.ra});
  assign rbs = signed'({1'b0, it_r.rb});
  assign rcs = signed'({1'b0, it_r.rc});

  tri_mul #(.AW(CW), .BW(CW)) u_sxa (.clk, .en, .a(it_r.xa), .b(it_r.xa), .p(sxa));
  tri_mul #(.AW(CW), .BW(CW)) u_sya (.clk, .en, .a(it_r.ya), .b(it_r.ya), .p(sya));
  tri_mul #(.AW(CW), .BW(CW)) u_sra (.clk, .en, .a(ras), .b(ras), .p(sra));
  tri_mul #(.AW(CW), .BW(CW)) u_sxb (.clk, .en, .a(it_r.xb), .b(it_r.xb), .p(sxb));
  tri_mul #(.AW(CW), .BW(CW)) u_syb (.clk, .en, .a(it_r.yb), .b(it_r.yb), .p(syb));
  tri_mul #(.AW(CW), .BW(CW)) u_srb (.clk, .en, .a(rbs), .b(rbs), .p(srb));
  tri_mul #(.AW(CW), .BW(CW)) u_sxc (.clk, .en, .a(it_r.xc), .b(it_r.xc), .p(sxc));
  tri_mul #(.AW(CW), .BW(CW)) u_syc (.clk, .en, .a(it_r.yc), .b(it_r.yc), .p(syc));
  tri_mul #(.AW(CW), .BW(CW)) u_src (.clk, .en, .a(rcs), .b(rcs), .p(src));
  tri_mul #(.AW(DFW), .BW(DFW)) u_pd1 (.clk, .en, .a(it_r.dxb), .b(it_r.dyc), .p(pd1));
  tri_mul #(.AW(DFW), .BW(DFW)) u_pd2 (.clk, .en, .a(it_r.dxc), .b(it_r.dyb), .p(pd2));

  tri_dly #(.W(D1W), .N(MUL_LAT)) u_dl1 (
    .clk, .en,
    .d({it_r.dxb, it_r.dyb, it_r.dxc, it_r.dyc, it_r.all_eq}),
    .q(dl1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ta_r <= TW'(sxa) + TW'(sya) - TW'(sra);
      tb_r <= TW'(sxb) + TW'(syb) - TW'(srb);
      tc_r <= TW'(sxc) + TW'(syc) - TW'(src);
      dd_r <= DAW'(pd1) - DAW'(pd2);
      {dxb_b_r, dyb_b_r, dxc_b_r, dyc_b_r, alleq_b_r} <= dl1;
    end
  end

  assign dabs = dd_r[DAW-1] ? DAW'(-dd_r) : DAW'(dd_r);

  always_ff @(posedge clk) begin
    if (en) begin
      cb_r     <= CBW'(tb_r) - CBW'(ta_r);
      cc_r     <= CBW'(tc_r) - CBW'(ta_r);
      dxb_c_r  <= dxb_b_r;
      dyb_c_r  <= dyb_b_r;
      dxc_c_r  <= dxc_b_r;
      dyc_c_r  <= dyc_b_r;
      den_c_r  <= {dabs, 1'b0};
      dneg_c_r <= dd_r[DAW-1];
      if (alleq_b_r) begin
        st_c_r <= ST_ALLX;
      end else if (dabs < (DAW'(1) << FRAC_BITS)) begin
        st_c_r <= ST_COLL;
      end else begin
        st_c_r <= ST_OK;
      end
    end
  end

  tri_mul #(.AW(CBW), .BW(DFW)) u_p1 (.clk, .en, .a(cb_r), .b(dyc_c_r), .p(p1));
  tri_mul #(.AW(CBW), .BW(DFW)) u_p2 (.clk, .en, .a(cc_r), .b(dyb_c_r), .p(p2));
  tri_mul #(.AW(CBW), .BW(DFW)) u_p3 (.clk, .en, .a(cc_r), .b(dxb_c_r), .p(p3));
  tri_mul #(.AW(CBW), .BW(DFW)) u_p4 (.clk, .en, .a(cb_r), .b(dxc_c_r), .p(p4));

  tri_dly #(.W(D2W), .N(MUL_LAT)) u_dl2 (
    .clk, .en,
    .d({den_c_r, dneg_c_r, st_c_r}),
    .q(dl2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r <= NUM_W'(p1) - NUM_W'(p2);
      ny_r <= NUM_W'(p3) - NUM_W'(p4);
      {den_d_r, dneg_d_r, st_d_r} <= dl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nmx_r   <= nx_r[NUM_W-1] ? NUM_W'(-nx_r) : NUM_W'(nx_r);
      nmy_r   <= ny_r[NUM_W-1] ? NUM_W'(-ny_r) : NUM_W'(ny_r);
      sx_r    <= nx_r[NUM_W-1] ^ dneg_d_r;
      sy_r    <= ny_r[NUM_W-1] ^ dneg_d_r;
      den_e_r <= den_d_r;
      st_e_r  <= st_d_r;
    end
  end

  tri_div u_divx (.clk, .en, .num(nmx_r), .den(den_e_r), .neg(sx_r), .q(qx));
  tri_div u_divy (.clk, .en, .num(nmy_r), .den(den_e_r), .neg(sy_r), .q(qy));

  tri_dly #(.W(2), .N(DIV_LAT)) u_dl3 (.clk, .en, .d(st_e_r), .q(st_q));

  always_ff @(posedge clk) begin
    if (en) begin
      tx_r <= (st_q == ST_OK) ? qx : '0;
      ty_r <= (st_q == ST_OK) ? qy : '0;
      st_r <= st_q;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.target_x   = tx_r;
  assign out_ch.target_y   = ty_r;
  assign out_ch.fix_status = st_r;

endmodule

[sv/trilateration_three_anchors.sv]
// Throughput: one request per cycle; the back pipeline holds while its output register is full.
// Depth is set by two multiplier stages and a radix-2 divider.
// Reset clears the queue, the valid chain and the output valid flag, and loads the
// tolerance register with 3; datapath registers are not reset.
module trilateration_three_anchors import tri_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  tri_in_if.sink     in_ch,
  tri_out_if.source  out_ch,
  tri_cfg_if.sink    cfg_ch
);

  logic      f_valid;
  logic      f_ready;
  tri_item_t f_item;
  logic      q_valid;
  logic      q_ready;
  tri_item_t q_item;

  tri_front u_front (
    .clk, .rst_n,
    .in_ch, .cfg_ch,
    .item_valid(f_valid),
    .item_ready(f_ready),
    .item(f_item)
  );

  tri_fifo #(.W($bits(tri_item_t))) u_fifo (
    .clk, .rst_n,
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_data(f_item),
    .pop_valid(q_valid),
    .pop_ready(q_ready),
    .pop_data(q_item)
  );

  tri_back u_back (
    .clk, .rst_n,
    .item_valid(q_valid),
    .item_ready(q_ready),
    .item(q_item),
    .out_ch
  );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tri_pkg::*;

  typedef struct {
    logic signed [CW-1:0] xa, ya, xb, yb, xc, yc;
    logic [RW-1:0]        ra, rb, rc;
  } fix_req_t;

  typedef struct {
    logic signed [CW-1:0] tx, ty;
    logic [1:0]           st;
  } fix_res_t;

  typedef struct {
    fix_req_t req;
    logic     typed;
    fix_res_t res;
  } fix_row_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2 * PIPE_LAT + 20;
  localparam int RAND_PER_PHASE = 250;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tri_in_if  in_ch();
  tri_out_if out_ch();
  tri_cfg_if cfg_ch();

  trilateration_three_anchors dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  logic [TOL_W-1:0] tol_model = TOL_RESET;
  fix_res_t         fix_q[$];
  logic             typed_q[$];
  fix_res_t         typed_res_q[$];
  int               idle_pct, stall_pct;
  int               errors = 0;
  int               n_req = 0;
  int               n_res = 0;
  int               n_allx = 0;
  int               n_coll = 0;
  int               n_ok = 0;
  int               quiet = 0;

  function automatic logic signed [CW-1:0] div_round_sat(logic signed [127:0] num,
                                                         logic signed [127:0] den);
    logic [127:0] mn, md, q, r, lim;
    logic         neg;
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = mn / md;
    r = mn % md;
    if (r >= md - r) q = q + 1;
    neg = (num < 0) != (den < 0);
    lim = neg ? (128'd1 << (CW - 1)) : (128'd1 << (CW - 1)) - 1;
    if (q > lim) q = lim;
    return neg ? -q[CW-1:0] : q[CW-1:0];
  endfunction

  function automatic fix_res_t solve_fix(fix_req_t f, logic [TOL_W-1:0] tol);
    logic signed [127:0] xa, ya, xb, yb, xc, yc, ra, rb, rc, t, ta, cb, cc, d;
    logic signed [127:0] dxb, dyb, dxc, dyc, adb, adc, ad;
    fix_res_t res;
    xa = f.xa; ya = f.ya; xb = f.xb; yb = f.yb; xc = f.xc; yc = f.yc;
    ra = {100'd0, f.ra}; rb = {100'd0, f.rb}; rc = {100'd0, f.rc};
    t = {112'd0, tol};
    res.tx = '0;
    res.ty = '0;
    adb = xa - xb; if (adb < 0) adb = -adb;
    adc = xa - xc; if (adc < 0) adc = -adc;
    if (adb < t && adc < t) begin
      res.st = ST_ALLX;
      return res;
    end
    dxb = xb - xa; dyb = yb - ya; dxc = xc - xa; dyc = yc - ya;
    d = dxb * dyc - dxc * dyb;
    ad = d < 0 ? -d : d;
    if (ad < (128'sd1 <<< FRAC_BITS)) begin
      res.st = ST_COLL;
      return res;
    end
    ta = xa * xa + ya * ya - ra * ra;
    cb = xb * xb + yb * yb - rb * rb - ta;
    cc = xc * xc + yc * yc - rc * rc - ta;
    res.tx = div_round_sat(cb * dyc - cc * dyb, 2 * d);
    res.ty = div_round_sat(dxb * cc - dxc * cb, 2 * d);
    res.st = ST_OK;
    return res;
  endfunction

  function automatic logic [RW-1:0] dist_of(longint dx, longint dy);
    logic [63:0] v, root, bitv;
    v = dx * dx + dy * dy;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      bitv = root | (64'd1 << i);
      if (bitv * bitv <= v) root = bitv;
    end
    if (root > 64'h0FFF_FFFF) root = 64'h0FFF_FFFF;
    return root[RW-1:0];
  endfunction

  function automatic int rnd_s(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic fix_req_t make_fix();
    fix_req_t f;
    int       kind, span, tx, ty, dx, dy, k, m;
    kind = $urandom_range(99);
    case ($urandom_range(9))
      0: span = 1 << 26;
      1, 2: span = 1 << 20;
      default: span = 1 << 12;
    endcase
    if (kind < 15) begin
      f.xa = CW'($urandom()); f.ya = CW'($urandom()); f.xb = CW'($urandom());
      f.yb = CW'($urandom()); f.xc = CW'($urandom()); f.yc = CW'($urandom());
      f.ra = RW'($urandom()); f.rb = RW'($urandom()); f.rc = RW'($urandom());
      return f;
    end
    tx = rnd_s(span); ty = rnd_s(span);
    f.xa = CW'(rnd_s(span)); f.ya = CW'(rnd_s(span));
    if (kind < 27) begin
      f.xb = CW'(f.xa + rnd_s($urandom_range(1) ? 4 : 70000));
      f.xc = CW'(f.xa + rnd_s($urandom_range(1) ? 4 : 70000));
      f.yb = CW'(rnd_s(span)); f.yc = CW'(rnd_s(span));
    end else if (kind < 37) begin
      dx = rnd_s(span / 4); dy = rnd_s(span / 4);
      k = rnd_s(3); m = rnd_s(3);
      f.xb = CW'(f.xa + k * dx); f.yb = CW'(f.ya + k * dy);
      f.xc = CW'(f.xa + m * dx + rnd_s(1)); f.yc = CW'(f.ya + m * dy + rnd_s(1));
    end else begin
      f.xb = CW'(rnd_s(span)); f.yb = CW'(rnd_s(span));
      f.xc = CW'(rnd_s(span)); f.yc = CW'(rnd_s(span));
    end
    f.ra = RW'(dist_of(longint'(f.xa) - tx, longint'(f.ya) - ty) + rnd_s(2));
    f.rb = RW'(dist_of(longint'(f.xb) - tx, longint'(f.yb) - ty) + rnd_s(2));
    f.rc = RW'(dist_of(longint'(f.xc) - tx, longint'(f.yc) - ty) + rnd_s(2));
    return f;
  endfunction

  task automatic send_fix(fix_req_t f, logic typed, fix_res_t res);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    typed_q.push_back(typed);
    typed_res_q.push_back(res);
    in_ch.valid      <= 1'b1;
    in_ch.anchor_a_x <= f.xa; in_ch.anchor_a_y <= f.ya; in_ch.range_a <= f.ra;
    in_ch.anchor_b_x <= f.xb; in_ch.anchor_b_y <= f.yb; in_ch.range_b <= f.rb;
    in_ch.anchor_c_x <= f.xc; in_ch.anchor_c_y <= f.yc; in_ch.range_c <= f.rc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_and_set_tol(logic [TOL_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fix_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    fix_res_t e;
    fix_req_t f;
    logic     acc;
    if (rst_n) begin
      acc = 1'b0;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tol_model = cfg_ch.data;
        acc = 1'b1;
      end
      if (in_ch.valid && in_ch.ready) begin
        f.xa = in_ch.anchor_a_x; f.ya = in_ch.anchor_a_y; f.ra = in_ch.range_a;
        f.xb = in_ch.anchor_b_x; f.yb = in_ch.anchor_b_y; f.rb = in_ch.range_b;
        f.xc = in_ch.anchor_c_x; f.yc = in_ch.anchor_c_y; f.rc = in_ch.range_c;
        e = solve_fix(f, tol_model);
        if (typed_q.size() != 0) begin
          if (typed_q.pop_front()) e = typed_res_q.pop_front();
          else void'(typed_res_q.pop_front());
        end
        fix_q.push_back(e);
        n_req++;
        acc = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        acc = 1'b1;
        n_res++;
        if (fix_q.size() == 0) begin
          $error("unexpected result x=%0d y=%0d status=%0d",
                 out_ch.target_x, out_ch.target_y, out_ch.fix_status);
          errors++;
        end else begin
          e = fix_q.pop_front();
          case (e.st)
            ST_ALLX: n_allx++;
            ST_COLL: n_coll++;
            default: n_ok++;
          endcase
          if (out_ch.target_x !== e.tx) begin
            $error("target_x expected %0d actual %0d", e.tx, out_ch.target_x);
            errors++;
          end
          if (out_ch.target_y !== e.ty) begin
            $error("target_y expected %0d actual %0d", e.ty, out_ch.target_y);
            errors++;
          end
          if (out_ch.fix_status !== e.st) begin
            $error("fix_status expected %0d actual %0d", e.st, out_ch.fix_status);
            errors++;
          end
        end
      end
      quiet = acc ? 0 : quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", fix_q.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    fix_row_t         rows[$];
    fix_row_t         row;
    fix_res_t         zero_res;
    logic [TOL_W-1:0] tols[5];
    int               modes_idle[4];
    int               modes_stall[4];

    idle_pct = 0; stall_pct = 0;
    in_ch.valid <= 1'b0;
    in_ch.anchor_a_x <= '0; in_ch.anchor_a_y <= '0; in_ch.range_a <= '0;
    in_ch.anchor_b_x <= '0; in_ch.anchor_b_y <= '0; in_ch.range_b <= '0;
    in_ch.anchor_c_x <= '0; in_ch.anchor_c_y <= '0; in_ch.range_c <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    zero_res = '{tx: '0, ty: '0, st: ST_OK};

    row.typed = 1'b1;
    row.req = '{xa: 0, ya: 0, xb: 0, yb: 0, xc: 0, yc: 0, ra: 0, rb: 0, rc: 0};
    row.res = '{tx: '0, ty: '0, st: ST_ALLX};
    rows.push_back(row);
    row.req = '{xa: 0, ya: -500, xb: 2, yb: 900, xc: -2, yc: 7, ra: 9, rb: 1, rc: 5};
    rows.push_back(row);
    row.req = '{xa: 0, ya: 0, xb: 256, yb: 0, xc: 512, yc: 0, ra: 100, rb: 0, rc: 50};
    row.res = '{tx: '0, ty: '0, st: ST_COLL};
    rows.push_back(row);
    row.req = '{xa: 0, ya: 0, xb: 15, yb: 0, xc: 0, yc: 17, ra: 0, rb: 0, rc: 0};
    rows.push_back(row);
    row.req = '{xa: 0, ya: 0, xb: 2560, yb: 0, xc: 0, yc: 2560, ra: 572, rb: 2366, rc: 2111};
    row.typed = 1'b0;
    rows.push_back(row);
    row.req = '{xa: 0, ya: 0, xb: 16, yb: 0, xc: 0, yc: 16,
                ra: 28'hFFFFFFF, rb: 0, rc: 0};
    rows.push_back(row);
    row.req = '{xa: 0, ya: 0, xb: 16, yb: 0, xc: 0, yc: 16,
                ra: 0, rb: 28'hFFFFFFF, rc: 0};
    rows.push_back(row);
    row.req = '{xa: -29'sd268435456, ya: -29'sd268435456, xb: 29'sd268435455,
                yb: -29'sd268435456, xc: -29'sd268435456, yc: 29'sd268435455,
                ra: 28'hFFFFFFF, rb: 0, rc: 28'hFFFFFFF};
    rows.push_back(row);
    row.req = '{xa: 29'sd268435455, ya: 29'sd268435455, xb: -29'sd268435456,
                yb: 29'sd268435455, xc: 29'sd268435455, yc: -29'sd268435456,
                ra: 0, rb: 28'hFFFFFFF, rc: 0};
    rows.push_back(row);
    row.req = '{xa: -1000, ya: 3000, xb: 4000, yb: -2000, xc: 7000, yc: 9000,
                ra: 28'h5555555, rb: 28'hAAAAAAA, rc: 12345};
    rows.push_back(row);

    tols = '{16'd0, 16'hFFFF, 16'd1, 16'd3, 16'd0};
    tols[4] = 16'($urandom());
    modes_idle  = '{0, 57, 0, 31};
    modes_stall = '{0, 0, 57, 31};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_fix(rows[i].req, rows[i].typed, rows[i].res);

    for (int p = 0; p < 5; p++) begin
      drain_and_set_tol(tols[p]);
      idle_pct  = modes_idle[p % 4];
      stall_pct = modes_stall[p % 4];
      for (int i = 0; i < RAND_PER_PHASE; i++) send_fix(make_fix(), 1'b0, zero_res);
    end
    in_ch.valid <= 1'b0;

    while (fix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d fixes sent, %0d results checked: %0d solved, %0d equal-x, %0d collinear",
             n_req, n_res, n_ok, n_allx, n_coll);
    $display("tolerance settings 0, 1, 3, 65535 and random; four idle/stall mixes");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
